[src/sdf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

    // default fraction bits of the Q format
    localparam int FRAC_BITS_DEF = 16;

    // datapath widths fixed by the 32 bit fields
    localparam int D_W    = 33;   // p1 - p2, v1 - v2
    localparam int SQ_W   = 66;   // sum of squared separations
    localparam int ROOT_W = 35;   // square root result
    localparam int ERR_W  = 36;   // length minus rest length
    localparam int DAMP_W = 98;   // damping * dv * d per axis
    localparam int DSUM_W = 100;  // sum over three axes
    localparam int ES_W   = 68;   // err * stiffness
    localparam int NUM_W  = 63;   // |F| * |d| dividend

    // configuration register index
    typedef enum logic [2:0] {
        REG_REST  = 3'd0,
        REG_STIFF = 3'd1,
        REG_DAMP  = 3'd2,
        REG_LIMIT = 3'd3,
        REG_MODE  = 3'd4
    } t_reg_idx;

    // spring mode codes
    localparam logic [1:0] MODE_BOTH     = 2'd0;
    localparam logic [1:0] MODE_CONTRACT = 2'd1;
    localparam logic [1:0] MODE_EXPAND   = 2'd2;

    // one result item
    typedef struct packed {
        logic [31:0] fmag;
        logic [31:0] fz;
        logic [31:0] fy;
        logic [31:0] fx;
        logic        applied;
    } t_result;

endpackage

`default_nettype wire

[src/sdf_isqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one root bit per stage.
module sdf_isqrt #(
    parameter int NB = sdf_pkg::ROOT_W,
    parameter int RW = sdf_pkg::SQ_W,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [RW-1:0] i_rad,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NB-1:0]      o_root,
    output logic [SW-1:0]      o_side
);
    localparam int AW = 2 * NB;

    logic          r_v    [NB];
    logic [AW-1:0] r_rem  [NB];
    logic [NB-1:0] r_root [NB];
    logic [SW-1:0] r_side [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stg
        localparam int B = NB - 1 - k;
        logic          pv;
        logic [AW-1:0] prem;
        logic [NB-1:0] proot;
        logic [SW-1:0] pside;
        logic [AW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign prem  = AW'(i_rad);
            assign proot = '0;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign pside = r_side[k-1];
        end

        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
        assign trial = (AW'(proot) << (B + 1)) | (AW'(1) << (2 * B));
        assign ge    = (prem >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? prem - trial : prem;
                r_root[k] <= ge ? (proot | (NB'(1) << B)) : proot;
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[NB-1];
    assign o_root  = r_root[NB-1];
    assign o_side  = r_side[NB-1];

endmodule

`default_nettype wire

[src/sdf_div3.sv]
`timescale 1ns / 1ps
`default_nettype none

// Three-lane pipelined restoring divider, one quotient bit per stage,
// shared divisor per item.
module sdf_div3 #(
    parameter int NW = sdf_pkg::NUM_W,
    parameter int DW = sdf_pkg::ROOT_W,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num [3],
    input  wire logic [DW-1:0] i_den,
    input  wire logic [SW-1:0] i_side,
    output logic               o_valid,
    output logic [NW-1:0]      o_quo [3],
    output logic [SW-1:0]      o_side
);
    logic          r_v    [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];
    logic [NW-1:0] r_num  [NW][3];
    logic [DW-1:0] r_rem  [NW][3];
    logic [NW-1:0] r_quo  [NW][3];

    for (genvar k = 0; k < NW; k++) begin : g_stg
        localparam int B = NW - 1 - k;
        logic          pv;
        logic [DW-1:0] pden;
        logic [SW-1:0] pside;
        logic [NW-1:0] pnum [3];
        logic [DW-1:0] prem [3];
        logic [NW-1:0] pquo [3];

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign pden  = i_den;
            assign pside = i_side;
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign pnum[l] = i_num[l];
                assign prem[l] = '0;
                assign pquo[l] = '0;
            end
        end else begin : g_next
            assign pv    = r_v[k-1];
            assign pden  = r_den[k-1];
            assign pside = r_side[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_ln
                assign pnum[l] = r_num[k-1][l];
                assign prem[l] = r_rem[k-1][l];
                assign pquo[l] = r_quo[k-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        // shift in the next dividend bit, subtract when it fits
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [DW:0] sh;
            logic        ge;
            assign sh = {prem[l], pnum[l][B]};
            assign ge = (sh >= {1'b0, pden});

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[k][l] <= pnum[l];
                    r_rem[k][l] <= ge ? DW'(sh - {1'b0, pden}) : DW'(sh);
                    r_quo[k][l] <= ge ? (pquo[l] | (NW'(1) << B)) : pquo[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= pden;
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_side  = r_side[NW-1];
    for (genvar l = 0; l < 3; l++) begin : g_out
        assign o_quo[l] = r_quo[NW-1][l];
    end

endmodule

`default_nettype wire

[src/spring_damper_force.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Signals                                   | Item
// ---------+-----+-------------------------------------------+----------------------------
// s (in)   | in  | i_s_tvalid, o_s_tready, i_s_tdata[383:0]  | two anchors, pos and vel
// m (out)  | out | o_m_tvalid, i_m_tready, o_m_tdata[127:0], | force vector and magnitude
//          |     | o_m_tuser[0]                              |
// cfg      | in  | i_cfg_valid, o_cfg_ready, i_cfg_index,    | register write
//          |     | i_cfg_data                                |
//
// One item per cycle while the skid entry is empty. The square root takes one
// stage per root bit and the divider one stage per quotient bit. Synchronous
// active-low reset clears all valid bits and the configuration registers. An
// output register plus one skid entry decouple the pipeline from the output;
// the pipeline holds while the skid entry is full.
module spring_damper_force #(
    parameter int FRAC_BITS = sdf_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // first_pos_x, first_pos_y, first_pos_z, second_pos_x, second_pos_y,
    // second_pos_z, first_vel_x, first_vel_y, first_vel_z, second_vel_x,
    // second_vel_y, second_vel_z (32 bits each, lowest first)
    input  wire logic [383:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // force_x, force_y, force_z, force_magnitude (32 bits each, lowest first)
    output logic [127:0]      o_m_tdata,
    // applied
    output logic [0:0]        o_m_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);
    import sdf_pkg::*;

    localparam int TW = ((DSUM_W > ES_W + FRAC_BITS) ? DSUM_W : ES_W + FRAC_BITS) + 1;
    localparam int IS_SW = DSUM_W + 3 * D_W;
    localparam int DV_SW = 37;

    // configuration registers
    logic [30:0]        r_rest;
    logic signed [31:0] r_stiff;
    logic signed [31:0] r_damp;
    logic [30:0]        r_limit;
    logic [1:0]         r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= '0;
            r_stiff <= '0;
            r_damp  <= '0;
            r_limit <= '0;
            r_mode  <= MODE_BOTH;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_REST:  r_rest  <= i_cfg_data[30:0];
                REG_STIFF: r_stiff <= $signed(i_cfg_data);
                REG_DAMP:  r_damp  <= $signed(i_cfg_data);
                REG_LIMIT: r_limit <= i_cfg_data[30:0];
                REG_MODE:  r_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless the skid entry is occupied
    logic r_skid_v;
    logic en;
    assign en         = !r_skid_v;
    assign o_s_tready = en;

    // S0: separations
    logic                  r_s0_v;
    logic signed [D_W-1:0] r_s0_d  [3];
    logic signed [D_W-1:0] r_s0_dv [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s0_d[i]  <= D_W'($signed(i_s_tdata[32*i +: 32]))
                            - D_W'($signed(i_s_tdata[32*(3+i) +: 32]));
                r_s0_dv[i] <= D_W'($signed(i_s_tdata[32*(6+i) +: 32]))
                            - D_W'($signed(i_s_tdata[32*(9+i) +: 32]));
            end
        end
    end

    // S1: squares and damping * dv
    logic [D_W-1:0]        s0_abs [3];
    logic                  r_s1_v;
    logic [SQ_W-1:0]       r_s1_sq   [3];
    logic signed [64:0]    r_s1_dgdv [3];
    logic signed [D_W-1:0] r_s1_d    [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s0_abs[i] = r_s0_d[i][D_W-1] ? D_W'(-r_s0_d[i]) : D_W'(r_s0_d[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_sq[i]   <= SQ_W'(s0_abs[i]) * SQ_W'(s0_abs[i]);
                r_s1_dgdv[i] <= 65'(r_damp) * 65'(r_s0_dv[i]);
                r_s1_d[i]    <= r_s0_d[i];
            end
        end
    end

    // S2: partial products of (damping * dv) * d, sum of squares
    logic                  r_s2_v;
    logic [SQ_W-1:0]       r_s2_sq;
    logic signed [65:0]    r_s2_pplo [3];
    logic signed [65:0]    r_s2_pphi [3];
    logic signed [D_W-1:0] r_s2_d    [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_sq <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
            for (int i = 0; i < 3; i++) begin
                r_s2_pplo[i] <= 66'($signed({1'b0, r_s1_dgdv[i][31:0]})) * 66'(r_s1_d[i]);
                r_s2_pphi[i] <= 66'($signed(r_s1_dgdv[i][64:32])) * 66'(r_s1_d[i]);
                r_s2_d[i]    <= r_s1_d[i];
            end
        end
    end

    // S3: per-axis damping terms
    logic                     r_s3_v;
    logic [SQ_W-1:0]          r_s3_sq;
    logic signed [DAMP_W-1:0] r_s3_damp [3];
    logic signed [D_W-1:0]    r_s3_d    [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_sq <= r_s2_sq;
            for (int i = 0; i < 3; i++) begin
                r_s3_damp[i] <= (DAMP_W'(r_s2_pphi[i]) <<< 32) + DAMP_W'(r_s2_pplo[i]);
                r_s3_d[i]    <= r_s2_d[i];
            end
        end
    end

    // S4: damping sum
    logic                     r_s4_v;
    logic [SQ_W-1:0]          r_s4_sq;
    logic signed [DSUM_W-1:0] r_s4_dsum;
    logic signed [D_W-1:0]    r_s4_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_sq   <= r_s3_sq;
            r_s4_dsum <= DSUM_W'(r_s3_damp[0]) + DSUM_W'(r_s3_damp[1])
                       + DSUM_W'(r_s3_damp[2]);
            for (int i = 0; i < 3; i++) begin
                r_s4_d[i] <= r_s3_d[i];
            end
        end
    end

    // square root of the summed squares
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    logic [IS_SW-1:0]  sq_side;

    sdf_isqrt #(
        .NB (ROOT_W),
        .RW (SQ_W),
        .SW (IS_SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_rad   (r_s4_sq),
        .i_side  ({r_s4_dsum, r_s4_d[2], r_s4_d[1], r_s4_d[0]}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // E0: length error and mode skip
    logic signed [ERR_W-1:0] n_err;
    logic                    n_skip;
    logic                    r_e0_v;
    logic signed [ERR_W-1:0] r_e0_err;
    logic                    r_e0_skip;
    logic [ROOT_W-1:0]       r_e0_len;
    logic [IS_SW-1:0]        r_e0_side;

    always_comb begin
        n_err  = $signed({1'b0, sq_root}) - $signed({5'b0, r_rest});
        n_skip = ((r_mode == MODE_CONTRACT) && n_err[ERR_W-1])
              || ((r_mode == MODE_EXPAND) && !n_err[ERR_W-1] && (n_err != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_v <= 1'b0;
        end else if (en) begin
            r_e0_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e0_err  <= n_err;
            r_e0_skip <= n_skip;
            r_e0_len  <= sq_root;
            r_e0_side <= sq_side;
        end
    end

    // E1: err * stiffness partial products
    logic                   r_e1_v;
    logic signed [ES_W-1:0] r_e1_pslo;
    logic signed [ES_W-1:0] r_e1_pshi;
    logic                   r_e1_skip;
    logic [ROOT_W-1:0]      r_e1_len;
    logic [IS_SW-1:0]       r_e1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
        end else if (en) begin
            r_e1_v <= r_e0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e1_pslo <= ES_W'($signed({1'b0, r_e0_err[31:0]})) * ES_W'(r_stiff);
            r_e1_pshi <= ES_W'($signed(r_e0_err[ERR_W-1:32])) * ES_W'(r_stiff);
            r_e1_skip <= r_e0_skip;
            r_e1_len  <= r_e0_len;
            r_e1_side <= r_e0_side;
        end
    end

    // E2: spring term
    logic                   r_e2_v;
    logic signed [ES_W-1:0] r_e2_es;
    logic                   r_e2_skip;
    logic [ROOT_W-1:0]      r_e2_len;
    logic [IS_SW-1:0]       r_e2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_v <= 1'b0;
        end else if (en) begin
            r_e2_v <= r_e1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e2_es   <= (r_e1_pshi <<< 32) + r_e1_pslo;
            r_e2_skip <= r_e1_skip;
            r_e2_len  <= r_e1_len;
            r_e2_side <= r_e1_side;
        end
    end

    // E3: total force in Q(3*FRAC_BITS)
    logic signed [DSUM_W-1:0] e2_dsum;
    logic                     r_e3_v;
    logic signed [TW-1:0]     r_e3_total;
    logic                     r_e3_skip;
    logic [ROOT_W-1:0]        r_e3_len;
    logic [3*D_W-1:0]         r_e3_d;

    assign e2_dsum = $signed(r_e2_side[IS_SW-1 -: DSUM_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_v <= 1'b0;
        end else if (en) begin
            r_e3_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e3_total <= (TW'(r_e2_es) <<< FRAC_BITS) + TW'(e2_dsum);
            r_e3_skip  <= r_e2_skip;
            r_e3_len   <= r_e2_len;
            r_e3_d     <= r_e2_side[3*D_W-1:0];
        end
    end

    // E4: scale back and clamp
    logic signed [TW-1:0] e3_sh;
    logic signed [32:0]   e3_hb;
    logic signed [32:0]   e3_lb;
    logic signed [31:0]   n_f;
    logic                 r_e4_v;
    logic signed [31:0]   r_e4_f;
    logic                 r_e4_skip;
    logic [ROOT_W-1:0]    r_e4_len;
    logic [3*D_W-1:0]     r_e4_d;

    always_comb begin
        e3_sh = r_e3_total >>> (2 * FRAC_BITS);
        if (r_limit != '0) begin
            e3_hb = $signed({2'b0, r_limit});
            e3_lb = -$signed({2'b0, r_limit});
        end else begin
            e3_hb = 33'sh0_7FFF_FFFF;
            e3_lb = 33'sh1_8000_0000;
        end
        if (e3_sh > TW'(e3_hb)) begin
            n_f = e3_hb[31:0];
        end else if (e3_sh < TW'(e3_lb)) begin
            n_f = e3_lb[31:0];
        end else begin
            n_f = e3_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_v <= 1'b0;
        end else if (en) begin
            r_e4_v <= r_e3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e4_f    <= n_f;
            r_e4_skip <= r_e3_skip;
            r_e4_len  <= r_e3_len;
            r_e4_d    <= r_e3_d;
        end
    end

    // E5: dividends |F| * |d_i| and result signs
    logic [31:0]        e4_fmag;
    logic [D_W-1:0]     e4_dabs [3];
    logic               e4_dneg [3];
    logic [64:0]        e4_prod [3];
    logic               r_e5_v;
    logic [NUM_W-1:0]   r_e5_num [3];
    logic [2:0]         r_e5_neg;
    logic signed [31:0] r_e5_f;
    logic               r_e5_skip;
    logic [ROOT_W-1:0]  r_e5_len;

    always_comb begin
        e4_fmag = r_e4_f[31] ? 32'(-r_e4_f) : 32'(r_e4_f);
        for (int i = 0; i < 3; i++) begin
            e4_dneg[i] = r_e4_d[D_W*i + D_W - 1];
            e4_dabs[i] = e4_dneg[i] ? D_W'(-r_e4_d[D_W*i +: D_W]) : r_e4_d[D_W*i +: D_W];
            e4_prod[i] = 65'(e4_fmag) * 65'(e4_dabs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e5_v <= 1'b0;
        end else if (en) begin
            r_e5_v <= r_e4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e5_num[i] <= e4_prod[i][NUM_W-1:0];
                r_e5_neg[i] <= r_e4_f[31] != e4_dneg[i];
            end
            r_e5_f    <= r_e4_f;
            r_e5_skip <= r_e4_skip;
            r_e5_len  <= r_e4_len;
        end
    end

    // per-axis division by the length
    logic             dv_v;
    logic [NUM_W-1:0] dv_quo [3];
    logic [DV_SW-1:0] dv_side;

    sdf_div3 #(
        .NW (NUM_W),
        .DW (ROOT_W),
        .SW (DV_SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e5_v),
        .i_num   (r_e5_num),
        .i_den   (r_e5_len),
        .i_side  ({(r_e5_len == '0), r_e5_skip, r_e5_f, r_e5_neg}),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // final sign, cap and masking
    logic        fin_lenz;
    logic        fin_skip;
    logic [31:0] fin_f;
    logic [2:0]  fin_neg;
    logic [31:0] fin_c [3];
    t_result     n_res;

    assign {fin_lenz, fin_skip, fin_f, fin_neg} = dv_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (fin_skip || fin_lenz) begin
                fin_c[i] = '0;
            end else if (fin_neg[i]) begin
                fin_c[i] = ~dv_quo[i][31:0] + 32'd1;
            end else if (dv_quo[i][NUM_W-1:31] != '0) begin
                fin_c[i] = 32'h7FFF_FFFF;
            end else begin
                fin_c[i] = dv_quo[i][31:0];
            end
        end
        n_res.fx      = fin_c[0];
        n_res.fy      = fin_c[1];
        n_res.fz      = fin_c[2];
        n_res.fmag    = fin_skip ? 32'd0 : fin_f;
        n_res.applied = !fin_skip;
    end

    // output register with one skid entry
    logic    r_out_v;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take = r_out_v && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (dv_v) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (dv_v) begin
            if (!r_out_v || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_m_tvalid   = r_out_v;
    assign o_m_tdata    = {r_out.fmag, r_out.fz, r_out.fy, r_out.fx};
    assign o_m_tuser[0] = r_out.applied;

endmodule

`default_nettype wire

[sim/spring_damper_force_tb.sv]
`timescale 1ns / 1ps

module spring_damper_force_tb;
    import sdf_pkg::*;

    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH = 110;
    localparam int CYCLE_CAP  = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [383:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [127:0] o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    spring_damper_force #(.FRAC_BITS(FRAC)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the spring settings
    logic [30:0]        rest_q;
    logic signed [31:0] stiff_q;
    logic signed [31:0] damp_q;
    logic [30:0]        limit_q;
    logic [1:0]         mode_q;

    logic [383:0] spring_items[$];
    t_result      force_expected[$];
    int           mismatches;
    int           n_forces;
    int           n_skipped;
    int           n_zero_len;
    int           cycles;
    bit           steady;

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // expected force item for one spring
    function automatic t_result spring_force(input logic [383:0] it);
        logic signed [32:0]  d[3];
        logic signed [32:0]  dv[3];
        logic [32:0]         ad;
        logic [65:0]         sq;
        logic [34:0]         root;
        logic [34:0]         c;
        logic [69:0]         csq;
        logic signed [35:0]  err;
        logic signed [127:0] tot;
        logic signed [63:0]  hb;
        logic signed [63:0]  lb;
        logic signed [63:0]  f;
        logic [63:0]         mf;
        logic [63:0]         q;
        logic [31:0]         comp[3];
        t_result             r;
        r = '0;
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            d[i]  = $signed(it[32*i +: 32]) - $signed(it[32*(i+3) +: 32]);
            dv[i] = $signed(it[32*(i+6) +: 32]) - $signed(it[32*(i+9) +: 32]);
            ad = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
            sq = sq + 66'(ad) * 66'(ad);
        end
        root = '0;
        for (int b = 34; b >= 0; b--) begin
            c = root | (35'd1 << b);
            csq = 70'(c) * 70'(c);
            if (csq <= 70'(sq)) root = c;
        end
        err = $signed({1'b0, root}) - $signed({5'd0, rest_q});
        // one-sided modes drop the step
        if (mode_q == MODE_CONTRACT && err < 0) return r;
        if (mode_q == MODE_EXPAND && err > 0) return r;
        tot = err;
        tot = tot * stiff_q;
        tot = tot <<< FRAC;
        for (int i = 0; i < 3; i++)
            tot = tot + 128'(damp_q) * 128'(dv[i]) * 128'(d[i]);
        tot = tot >>> (2 * FRAC);
        hb = (limit_q != 0) ? 64'(limit_q) : 64'sh7FFFFFFF;
        lb = (limit_q != 0) ? -64'(limit_q) : -64'sh80000000;
        if (tot > hb) f = hb;
        else if (tot < lb) f = lb;
        else f = tot[63:0];
        for (int i = 0; i < 3; i++) comp[i] = '0;
        if (root != 0) begin
            mf = f[63] ? 64'(-f) : 64'(f);
            for (int i = 0; i < 3; i++) begin
                ad = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
                q = (mf * 64'(ad)) / 64'(root);
                if (f[63] != d[i][32]) comp[i] = 32'(-q);
                else comp[i] = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            end
        end
        r.fx = comp[0];
        r.fy = comp[1];
        r.fz = comp[2];
        r.fmag = f[31:0];
        r.applied = 1'b1;
        return r;
    endfunction

    // spring item driver
    int feed_gap;
    always @(posedge i_clk) begin
        logic accepted;
        accepted = i_s_tvalid && o_s_tready;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (accepted) begin
                force_expected.push_back(spring_force(spring_items.pop_front()));
                feed_gap = pick_gap();
            end
            if ((accepted || !i_s_tvalid) && feed_gap > 0) begin
                feed_gap--;
                i_s_tvalid <= 1'b0;
            end else if (spring_items.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= spring_items[0];
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // force item monitor and random back-pressure
    int stall_left;
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (force_expected.size() == 0) begin
                    $error("unexpected force item %h / %b", o_m_tdata, o_m_tuser);
                    mismatches++;
                end else begin
                    want = force_expected.pop_front();
                    n_forces++;
                    if (!want.applied) n_skipped++;
                    else if (want.fx == 0 && want.fy == 0 && want.fz == 0) n_zero_len++;
                    if (o_m_tdata[31:0] !== want.fx) begin
                        $error("force_x exp %h got %h", want.fx, o_m_tdata[31:0]);
                        mismatches++;
                    end
                    if (o_m_tdata[63:32] !== want.fy) begin
                        $error("force_y exp %h got %h", want.fy, o_m_tdata[63:32]);
                        mismatches++;
                    end
                    if (o_m_tdata[95:64] !== want.fz) begin
                        $error("force_z exp %h got %h", want.fz, o_m_tdata[95:64]);
                        mismatches++;
                    end
                    if (o_m_tdata[127:96] !== want.fmag) begin
                        $error("force_magnitude exp %h got %h", want.fmag,
                               o_m_tdata[127:96]);
                        mismatches++;
                    end
                    if (o_m_tuser[0] !== want.applied) begin
                        $error("applied exp %b got %b", want.applied, o_m_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                stall_left = pick_gap();
                i_m_tready <= (stall_left == 0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("spring_damper_force_tb: errors");
            $finish;
        end
    end

    // one register write, shadow updated on the handshake
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_REST:  rest_q = val[30:0];
            REG_STIFF: stiff_q = val;
            REG_DAMP:  damp_q = val;
            REG_LIMIT: limit_q = val[30:0];
            default:   mode_q = val[1:0];
        endcase
    endtask

    task automatic set_spring(input logic [31:0] rest, input logic [31:0] stiff,
                              input logic [31:0] damp, input logic [31:0] lim,
                              input logic [31:0] mode);
        write_reg(REG_REST, rest);
        write_reg(REG_STIFF, stiff);
        write_reg(REG_DAMP, damp);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_MODE, mode);
    endtask

    // block idle: nothing queued, nothing owed, pipeline flushed
    task automatic drain();
        while (spring_items.size() > 0 || force_expected.size() > 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return $urandom();
        if (r < 80) return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
        if (r < 90) return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [383:0] rand_spring();
        logic [383:0] it;
        for (int i = 0; i < 12; i++) it[32*i +: 32] = rand_coord();
        // coincident anchors now and then
        if ($urandom_range(0, 19) == 0) it[191:96] = it[95:0];
        return it;
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return $urandom();
            3: return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
            default: return $urandom_range(0, 32'h20000);
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 4))
            0: return 32'h7FFFFFFF;
            1: return 32'h0;
            2: return $urandom();
            default: return $urandom_range(0, 32'h100000);
        endcase
    endfunction

    // directed springs, all fields from the given coordinates
    task automatic push_uniform(input logic [31:0] p1, input logic [31:0] p2,
                                input logic [31:0] v1, input logic [31:0] v2);
        spring_items.push_back({{3{v2}}, {3{v1}}, {3{p2}}, {3{p1}}});
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_REST;
        i_cfg_data = '0;
        rest_q = '0;
        stiff_q = '0;
        damp_q = '0;
        limit_q = '0;
        mode_q = MODE_BOTH;
        mismatches = 0;
        n_forces = 0;
        n_skipped = 0;
        n_zero_len = 0;
        cycles = 0;
        steady = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every force is zero
        push_uniform(32'h00010000, 32'h0, 32'h0, 32'h0);
        push_uniform(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        drain();

        // directed: unit spring, both ways, no clamp
        set_spring(32'h00010000, 32'h00010000, 32'h00008000, 32'h0, MODE_BOTH);
        push_uniform(32'h0, 32'h0, 32'h0, 32'h0);                    // zero length
        push_uniform(32'h00050000, 32'h00050000, 32'h00010000, 32'h0); // zero length, moving
        push_uniform(32'h00020000, 32'h0, 32'h0, 32'h0);
        push_uniform(32'h0, 32'h00020000, 32'h00010000, 32'hFFFF0000);
        push_uniform(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        push_uniform(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        push_uniform(32'hFFFFFFFF, 32'h00000001, 32'h0, 32'hFFFFFFFF);
        push_uniform(32'h00000001, 32'h0, 32'h0, 32'h0);
        drain();
        // clamp, contract only and expand only around the rest length
        for (int m = 0; m < 4; m++) begin
            set_spring(32'h00030000, 32'h7FFFFFFF, 32'h80000000,
                       (m == 3) ? 32'h7FFFFFFF : 32'h00001000, m);
            push_uniform(32'h00010000, 32'h0, 32'h0, 32'h0);         // shorter than rest
            push_uniform(32'h00040000, 32'h0, 32'h0, 32'h0);         // longer than rest
            push_uniform(32'h0, 32'h0, 32'h00010000, 32'h0);         // zero length
            drain();
        end

        // random phases under varied settings
        for (int ph = 0; ph < 10; ph++) begin
            steady = (ph % 4 == 3);
            set_spring(rand_len(), rand_gain(), rand_gain(),
                       ($urandom_range(0, 2) == 0) ? 32'h0 : rand_len(),
                       (ph < 4) ? ph : $urandom_range(0, 3));
            for (int n = 0; n < 60; n++) spring_items.push_back(rand_spring());
            drain();
        end
        steady = 1'b0;

        $display("covered %0d force items: %0d skipped by mode, %0d with a zero vector",
                 n_forces, n_skipped, n_zero_len);
        $display("settings: reset, unit spring, clamp and each spring mode, 10 random");
        if (mismatches == 0 && force_expected.size() == 0) begin
            $display("spring_damper_force_tb: clean");
        end else begin
            $display("spring_damper_force_tb: errors");
        end
        $finish;
    end

endmodule
